[hw/rtl/mpsg_pkg.sv]
// ---------------------------------------------------------------------------
// mpsg_pkg
// Shared constants and types of the maximum falling path sum block.
// ---------------------------------------------------------------------------
package mpsg_pkg;

   // fixed field widths
   localparam int VALUE_W    = 16;
   localparam int NUM_COLS_W = 7;

   // column count after reset
   localparam logic [NUM_COLS_W-1:0] NUM_COLS_RESET = 7'd64;

   // per-element control carried from the accept stage into the sum stage
   typedef struct packed {
      logic first_row;   // element belongs to the first row of the matrix
      logic col_first;   // element sits in column zero
      logic col_last;    // element sits in the last column of its row
      logic last;        // final element of the matrix
   } flags_type;

endpackage

[hw/rtl/mpsg_row_ram.sv]
// ---------------------------------------------------------------------------
// mpsg_row_ram
// Row buffer of path sums: one write and one read port, registered read
// data, write data forwarded when both ports hit the same entry.
// ---------------------------------------------------------------------------
module mpsg_row_ram #(
   parameter int DEPTH  = 64,
   parameter int WIDTH  = 32,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, write-first on an address match
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/max_path_sum_grid_dp.sv]
// ---------------------------------------------------------------------------
// max_path_sum_grid_dp
// Maximum falling path sum over a matrix streamed in row-major order.
// Result path: the end-of-matrix word passes the sum stage, then the result word register.
// Throughput: one word per cycle, one buffer read and write each, unless result-stalled.
// The read of column j+1 goes out at accept; column j's old sum comes from the prior read.
// Reset: control state clears, column count returns to 64; the row buffer is not cleared.
// Old sums are used only once the current matrix wrote them; first-row reads are ignored.
// ---------------------------------------------------------------------------
module max_path_sum_grid_dp #(
   parameter int MAX_COLS = 64,
   parameter int SUM_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // column count register
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mpsg_pkg::NUM_COLS_W-1:0]      csr_num_cols,
   // matrix elements
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [mpsg_pkg::VALUE_W-1:0]  req_value,
   input  logic                                 req_end_of_matrix,
   // result
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [SUM_BITS-1:0]           rsp_max_sum
);

   localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int CNT_W = COL_W + 1;
   localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};
   localparam logic signed [SUM_BITS-1:0] SUM_MAX = ~SUM_MIN;

   // ---------------- registers ----------------
   logic [mpsg_pkg::NUM_COLS_W-1:0]     num_cols_ff, num_cols_in;
   logic [COL_W-1:0]                    col_ff, col_in;
   logic                                first_row_ff, first_row_in;

   logic                                s1_valid_ff, s1_valid_in;
   mpsg_pkg::flags_type                 s1_flags_ff, s1_flags_in;
   logic signed [mpsg_pkg::VALUE_W-1:0] s1_value_ff, s1_value_in;
   logic [COL_W-1:0]                    s1_col_ff, s1_col_in;

   logic signed [SUM_BITS-1:0]          cur_old_ff, cur_old_in;
   logic signed [SUM_BITS-1:0]          left_old_ff, left_old_in;
   logic signed [SUM_BITS-1:0]          first_sum_ff, first_sum_in;
   logic signed [SUM_BITS-1:0]          row_best_ff, row_best_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [SUM_BITS-1:0]          rsp_sum_ff, rsp_sum_in;

   // ---------------- combinational ----------------
   logic                       csr_write;
   logic                       req_accept;
   logic                       stall;
   logic                       retire;
   logic [CNT_W-1:0]           cols_used;
   logic [CNT_W-1:0]           col_next;
   logic                       col_is_last;
   logic                       rd_en;
   logic signed [SUM_BITS-1:0] rd_data;
   logic signed [SUM_BITS-1:0] value_ext;
   logic signed [SUM_BITS-1:0] best;
   logic signed [SUM_BITS:0]   sum_wide;
   logic signed [SUM_BITS-1:0] sum;
   logic signed [SUM_BITS-1:0] row_best_upd;

   // handshakes: a held result word only blocks when the sum stage holds the last word
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign stall      = s1_valid_ff && s1_flags_ff.last && rsp_valid_ff && !rsp_ready;
   assign req_ready  = !stall;
   assign req_accept = req_valid && req_ready;
   assign retire     = s1_valid_ff && !stall;

   // column count clamped to 1..MAX_COLS
   always_comb begin
      if (num_cols_ff == '0) begin
         cols_used = CNT_W'(1);
      end else if (int'(num_cols_ff) > MAX_COLS) begin
         cols_used = CNT_W'(MAX_COLS);
      end else begin
         cols_used = CNT_W'(num_cols_ff);
      end
   end

   assign col_next    = {1'b0, col_ff} + CNT_W'(1);
   assign col_is_last = (col_next >= cols_used);
   // fetch the old sum one column ahead; none is needed past the row end
   assign rd_en       = req_accept && !col_is_last;

   // column tracking at accept
   always_comb begin
      num_cols_in  = num_cols_ff;
      col_in       = col_ff;
      first_row_in = first_row_ff;
      if (csr_write) begin
         num_cols_in  = csr_num_cols;
         col_in       = '0;
         first_row_in = 1'b1;
      end else if (req_accept) begin
         if (req_end_of_matrix) begin
            col_in       = '0;
            first_row_in = 1'b1;
         end else if (col_is_last) begin
            col_in       = '0;
            first_row_in = 1'b0;
         end else begin
            col_in = col_next[COL_W-1:0];
         end
      end
   end

   // sum stage loading
   always_comb begin
      s1_flags_in = s1_flags_ff;
      s1_value_in = s1_value_ff;
      s1_col_in   = s1_col_ff;
      if (req_accept) begin
         s1_valid_in           = 1'b1;
         s1_flags_in.first_row = first_row_ff;
         s1_flags_in.col_first = (col_ff == '0);
         s1_flags_in.col_last  = col_is_last;
         s1_flags_in.last      = req_end_of_matrix;
         s1_value_in           = req_value;
         s1_col_in             = col_ff;
      end else begin
         s1_valid_in = stall ? s1_valid_ff : 1'b0;
      end
   end

   // best of the up to three neighbors above (zero in first row), then saturating add
   assign value_ext = SUM_BITS'(s1_value_ff);

   always_comb begin
      if (s1_flags_ff.first_row) begin
         best = '0;
      end else begin
         best = cur_old_ff;
         if (!s1_flags_ff.col_first && (left_old_ff > best)) begin
            best = left_old_ff;
         end
         if (!s1_flags_ff.col_last && (rd_data > best)) begin
            best = rd_data;
         end
      end
   end

   assign sum_wide = {best[SUM_BITS-1], best} + {value_ext[SUM_BITS-1], value_ext};

   always_comb begin
      if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
         sum = sum_wide[SUM_BITS] ? SUM_MIN : SUM_MAX;
      end else begin
         sum = sum_wide[SUM_BITS-1:0];
      end
   end

   assign row_best_upd = (s1_flags_ff.col_first || (sum > row_best_ff)) ? sum : row_best_ff;

   // window of old sums and the running row best
   always_comb begin
      cur_old_in   = cur_old_ff;
      left_old_in  = left_old_ff;
      first_sum_in = first_sum_ff;
      row_best_in  = row_best_ff;
      if (csr_write) begin
         left_old_in = '0;
         row_best_in = SUM_MIN;
      end else if (retire) begin
         left_old_in = cur_old_ff;
         if (s1_flags_ff.col_first) begin
            first_sum_in = sum;
         end
         // at the row end the next old sum is this row's column zero
         if (s1_flags_ff.col_last) begin
            cur_old_in = s1_flags_ff.col_first ? sum : first_sum_ff;
         end else begin
            cur_old_in = rd_data;
         end
         row_best_in = s1_flags_ff.last ? SUM_MIN : row_best_upd;
      end
   end

   // result word register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_sum_in   = rsp_sum_ff;
      if (retire && s1_flags_ff.last) begin
         rsp_valid_in = 1'b1;
         rsp_sum_in   = row_best_upd;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_max_sum = rsp_sum_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         num_cols_ff  <= mpsg_pkg::NUM_COLS_RESET;
         col_ff       <= '0;
         first_row_ff <= 1'b1;
         s1_valid_ff  <= 1'b0;
         left_old_ff  <= '0;
         row_best_ff  <= SUM_MIN;
         rsp_valid_ff <= 1'b0;
      end else begin
         num_cols_ff  <= num_cols_in;
         col_ff       <= col_in;
         first_row_ff <= first_row_in;
         s1_valid_ff  <= s1_valid_in;
         left_old_ff  <= left_old_in;
         row_best_ff  <= row_best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_flags_ff  <= s1_flags_in;
      s1_value_ff  <= s1_value_in;
      s1_col_ff    <= s1_col_in;
      cur_old_ff   <= cur_old_in;
      first_sum_ff <= first_sum_in;
      rsp_sum_ff   <= rsp_sum_in;
   end

   // row buffer
   mpsg_row_ram #(
      .DEPTH  (MAX_COLS),
      .WIDTH  (SUM_BITS),
      .ADDR_W (COL_W)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (retire),
      .wr_addr (s1_col_ff),
      .wr_data (sum),
      .rd_en   (rd_en),
      .rd_addr (col_next[COL_W-1:0]),
      .rd_data (rd_data)
   );

   // ---------------- assertions ----------------
   // a result word only follows a retired end-of-matrix word
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff && s1_flags_ff.last))
      else $error("result word without end-of-matrix word");

   // nothing enters while the sum stage is blocked
   a_no_accept_in_stall: assert property (@(posedge clock) disable iff (reset)
      stall |-> !req_accept)
      else $error("word accepted while sum stage is stalled");

   // column counter stays inside the row
   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, col_ff} < cols_used))
      else $error("column index beyond row width");

   // an element both first and last in its row means a single column
   a_single_col: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_flags_ff.col_first && s1_flags_ff.col_last)
         |-> (cols_used == CNT_W'(1)))
      else $error("row end flag on column zero with more than one column");

   // a blocked end-of-matrix word keeps the sum stage occupied
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      stall |=> s1_valid_ff && s1_flags_ff.last)
      else $error("stalled end-of-matrix word lost");

endmodule
